>>> hdl/lbs_pkg.sv
// Package with the shared types and constants of the vertex skinning block.
`default_nettype none
package lbs_pkg;

  localparam int ELEMS_PER_BONE = 12;
  localparam int PROD_W         = 48;
  localparam int SUM_W          = 50;
  localparam int TERM_W         = 52;
  localparam int ACC_W          = 54;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SKIN = 1'b1;

  localparam logic [1:0] KIND_POSITION = 2'd0;

  typedef struct packed {
    logic        valid;
    logic        first;
    logic        last;
    logic        single;
    logic        trans;
    logic        zero;
    logic [15:0] w;
  } lbs_ctl_t;

  typedef struct packed {
    logic [15:0] vertex_index;
    logic [1:0]  kind;
    logic        last;
  } lbs_meta_t;

endpackage
`default_nettype wire

>>> hdl/lbs_in_if.sv
// Input channel of the skinning block: load and skin beats.
`default_nettype none
interface lbs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [9:0]  palette_address;
  logic signed [31:0] palette_value;
  logic [15:0] vertex_index;
  logic [1:0]  vector_kind;
  logic [2:0]  influence_count;
  logic [23:0] bone_ids;
  logic [63:0] blend_weights;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic        last_in_batch;

  modport source (output valid, mode, palette_address, palette_value, vertex_index,
                  vector_kind, influence_count, bone_ids, blend_weights, in_x, in_y,
                  in_z, last_in_batch, input ready);
  modport sink (input valid, mode, palette_address, palette_value, vertex_index,
                vector_kind, influence_count, bone_ids, blend_weights, in_x, in_y,
                in_z, last_in_batch, output ready);
endinterface
`default_nettype wire

>>> hdl/lbs_out_if.sv
// Result channel of the skinning block: one skinned vector per beat.
`default_nettype none
interface lbs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_vertex_index;
  logic [1:0]  out_kind;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic        out_last;
  logic        saturated;

  modport source (output valid, out_vertex_index, out_kind, out_x, out_y, out_z,
                  out_last, saturated, input ready);
  modport sink (input valid, out_vertex_index, out_kind, out_x, out_y, out_z,
                out_last, saturated, output ready);
endinterface
`default_nettype wire

>>> hdl/linear_blend_vertex_skinning.sv
// Top level of the linear blend vertex skinning block.
//
//   channel   direction  beat carries
//   in_ch     sink       palette load element, or vector with bones and weights
//   out_ch    source     skinned vector, vertex number, kind, saturation flag
//
// A skin beat is issued one influence at a time (1 to 4): the palette is twelve
// element RAMs read together, so one whole bone matrix comes out each cycle the
// pipeline advances. Results pass the read, product, sum, term and result
// registers. Reset is synchronous and clears control state only; the palette is
// not cleared and must be loaded before use. A stalled result freezes the whole
// pipeline, and input is refused until the result leaves.
`default_nettype none
module linear_blend_vertex_skinning
  import lbs_pkg::*;
#(
  parameter int NUM_BONES      = 64,
  parameter int MAX_INFLUENCES = 4
) (
  input wire logic clk,
  input wire logic rst_n,
  lbs_in_if.sink   in_ch,
  lbs_out_if.source out_ch
);
  localparam int AW = $clog2(NUM_BONES);

  // Pipeline advance: everything moves unless the result register is held.
  logic en;
  logic out_valid;
  assign en = !out_valid || out_ch.ready;

  // Sequencer state for the issued item: one influence per unstalled cycle.
  logic        busy_r;
  logic [1:0]  idx_r;
  logic [2:0]  cnt_r;
  logic [23:0] bones_r;
  logic [63:0] weights_r;
  logic [2:0][31:0] vec_r;
  logic        single_r, trans_r;
  lbs_meta_t   meta_r;

  logic        last_issue;
  logic        accept;
  logic [2:0]  cnt_in;
  logic [5:0]  bone;
  logic [15:0] weight;

  assign last_issue  = ({1'b0, idx_r} == cnt_r - 3'd1);
  assign in_ch.ready = en && (!busy_r || last_issue);
  assign accept      = in_ch.valid && in_ch.ready;

  // Influence count zero acts as one, counts above the maximum are clamped.
  always_comb begin
    if (in_ch.influence_count == 3'd0) begin
      cnt_in = 3'd1;
    end else if (32'(in_ch.influence_count) > MAX_INFLUENCES) begin
      cnt_in = 3'(MAX_INFLUENCES);
    end else begin
      cnt_in = in_ch.influence_count;
    end
  end

  assign bone   = bones_r[6*idx_r +: 6];
  assign weight = weights_r[16*idx_r +: 16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (en) begin
      if (accept && in_ch.mode == MODE_SKIN) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (busy_r && last_issue) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.mode == MODE_SKIN) begin
      cnt_r     <= cnt_in;
      bones_r   <= in_ch.bone_ids;
      weights_r <= in_ch.blend_weights;
      vec_r     <= {in_ch.in_z, in_ch.in_y, in_ch.in_x};
      single_r  <= (cnt_in == 3'd1);
      trans_r   <= (in_ch.vector_kind == KIND_POSITION);
      meta_r    <= '{vertex_index: in_ch.vertex_index, kind: in_ch.vector_kind,
                     last: in_ch.last_in_batch};
    end
  end

  // Palette load: address split into bone and element, bone = (addr/4)/3.
  // The quotient by three uses the reciprocal 171/512, exact for 0..255.
  logic [7:0]  ld_q;
  logic [15:0] ld_prod;
  logic [9:0]  ld_rem;
  logic [3:0]  ld_elem;
  logic        ld_ok;

  always_comb begin
    ld_prod = 16'(in_ch.palette_address[9:2]) * 16'd171;
    ld_q    = {1'b0, ld_prod[15:9]};
    ld_rem  = in_ch.palette_address - 10'(ld_q) * 10'd12;
    ld_elem = ld_rem[3:0];
    ld_ok   = accept && in_ch.mode == MODE_LOAD &&
              32'(in_ch.palette_address) < NUM_BONES * ELEMS_PER_BONE;
  end

  logic [11:0][31:0] m_rd;

  for (genvar k = 0; k < ELEMS_PER_BONE; k++) begin : g_elem
    lbs_ram #(.WIDTH(32), .DEPTH(NUM_BONES)) u_ram (
      .clk  (clk),
      .we   (ld_ok && ld_elem == 4'(k)),
      .waddr(AW'(ld_q)),
      .wdata(in_ch.palette_value),
      .re   (en),
      .raddr(AW'(bone)),
      .rdata(m_rd[k])
    );
  end

  // Control and metadata pipeline beside the lanes.
  lbs_ctl_t  c1_r, c2_r, c3_r, c4_r, c0;
  lbs_meta_t m1_r, m2_r, m3_r, m4_r;
  logic [2:0][31:0] v1_r;

  always_comb begin
    c0.valid  = busy_r;
    c0.first  = (idx_r == 2'd0);
    c0.last   = last_issue;
    c0.single = single_r;
    c0.trans  = trans_r;
    c0.zero   = (32'(bone) >= NUM_BONES);
    c0.w      = weight;
  end

  // Only the valid bits are cleared by reset; the other fields follow them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r.valid <= 1'b0;
      c2_r.valid <= 1'b0;
      c3_r.valid <= 1'b0;
      c4_r.valid <= 1'b0;
    end else if (en) begin
      c1_r <= c0;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r <= vec_r;
      m1_r <= meta_r;
      m2_r <= m1_r;
      m3_r <= m2_r;
      m4_r <= m3_r;
    end
  end

  // Three lanes, one per matrix row (x, y, z of the result).
  logic [2:0][ACC_W-1:0] sums;

  for (genvar r = 0; r < 3; r++) begin : g_lane
    lbs_lane u_lane (
      .clk  (clk),
      .en   (en),
      .m_row({m_rd[4*r+3], m_rd[4*r+2], m_rd[4*r+1], m_rd[4*r]}),
      .vec  (v1_r),
      .ctl1 (c1_r),
      .ctl3 (c3_r),
      .ctl4 (c4_r),
      .sum  (sums[r])
    );
  end

  logic [2:0][31:0] res_vec;
  lbs_meta_t        res_meta;
  logic             res_sat;

  lbs_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .take   (c4_r.valid && c4_r.last),
    .sums   (sums),
    .meta   (m4_r),
    .valid_r(out_valid),
    .vec_r  (res_vec),
    .meta_r (res_meta),
    .sat_r  (res_sat)
  );

  assign out_ch.valid            = out_valid;
  assign out_ch.out_vertex_index = res_meta.vertex_index;
  assign out_ch.out_kind         = res_meta.kind;
  assign out_ch.out_last         = res_meta.last;
  assign out_ch.out_x            = res_vec[0];
  assign out_ch.out_y            = res_vec[1];
  assign out_ch.out_z            = res_vec[2];
  assign out_ch.saturated        = res_sat;
endmodule
`default_nettype wire

>>> hdl/lbs_ram.sv
// Generic single-port-write, registered-read RAM (read returns old data on collision).
`default_nettype none
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> hdl/lbs_lane.sv
// One matrix row lane: row dot product, weighting and accumulation over influences.
`default_nettype none
module lbs_lane
  import lbs_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [3:0][31:0]        m_row,
  input  wire logic [2:0][31:0]        vec,
  input  wire lbs_ctl_t                ctl1,
  input  wire lbs_ctl_t                ctl3,
  input  wire lbs_ctl_t                ctl4,
  output logic signed [ACC_W-1:0]      sum
);
  logic signed [63:0]          prod [3];
  logic signed [PROD_W-1:0]    p_r [3];
  logic signed [31:0]          tr_r;
  logic signed [SUM_W-1:0]     s_r, s_nxt;
  logic signed [SUM_W+16:0]    wide;
  logic signed [TERM_W-1:0]    term_r, term_nxt;
  logic signed [ACC_W-1:0]     acc_r;

  // Products are floored to Q32.16 by dropping the low sixteen bits.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = ctl1.zero ? 64'sd0 : $signed(m_row[c]) * $signed(vec[c]);
    end
  end

  always_comb begin
    s_nxt = SUM_W'(p_r[0]) + SUM_W'(p_r[1]) + SUM_W'(p_r[2]) + SUM_W'(tr_r);
    wide  = s_r * $signed({1'b0, ctl3.w});
    term_nxt = ctl3.single ? TERM_W'(s_r) : wide[SUM_W+16:15];
    sum   = (ctl4.first ? ACC_W'(0) : acc_r) + ACC_W'(term_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        p_r[c] <= prod[c][63:16];
      end
      tr_r   <= (ctl1.trans && !ctl1.zero) ? $signed(m_row[3]) : 32'sd0;
      s_r    <= s_nxt;
      term_r <= term_nxt;
      acc_r  <= sum;
    end
  end
endmodule
`default_nettype wire

>>> hdl/lbs_merge.sv
// Merges the three lane sums: saturation, clip flag and the result register.
`default_nettype none
module lbs_merge
  import lbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  take,
  input  wire logic [2:0][ACC_W-1:0] sums,
  input  wire lbs_meta_t             meta,
  output logic                       valid_r,
  output logic [2:0][31:0]           vec_r,
  output lbs_meta_t                  meta_r,
  output logic                       sat_r
);
  localparam logic signed [ACC_W-1:0] HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] LO = ACC_W'(-64'sd2147483648);

  logic [2:0][31:0] vec_nxt;
  logic [2:0]       clip;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip[r] = 1'b1;
      if ($signed(sums[r]) > HI) begin
        vec_nxt[r] = 32'h7fff_ffff;
      end else if ($signed(sums[r]) < LO) begin
        vec_nxt[r] = 32'h8000_0000;
      end else begin
        vec_nxt[r] = sums[r][31:0];
        clip[r]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en && take) begin
      vec_r  <= vec_nxt;
      meta_r <= meta;
      sat_r  <= |clip;
    end
  end
endmodule
`default_nettype wire

>>> hdl/lbs_checker.sv
// Port-level checker for the skinning block, bound to the top level.
`default_nettype none
module lbs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_x
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x))
    else $error("result payload changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  a_no_early_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");
endmodule

bind linear_blend_vertex_skinning lbs_checker u_lbs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_x    (out_ch.out_x)
);
`default_nettype wire
